FILE: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the charge accounting unit
// Request and result structs, operation codes and serial step counts.
// ----------------------------------------------------------------------------
package cau_pkg;

	// Field widths
	localparam int OPD_W      = 32;
	localparam int PROD_W     = 2 * OPD_W;
	localparam int HOURS_W    = 32;
	localparam int REM_OUT_W  = 27;
	localparam int CAT_FLD_W  = 2;

	// Time base
	localparam int SECONDS_PER_MINUTE = 60;
	localparam int SECONDS_PER_HOUR   = SECONDS_PER_MINUTE * SECONDS_PER_MINUTE;

	// Serial step counters
	localparam int MUL_CNT_W = $clog2(OPD_W);
	localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(OPD_W - 1);
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

	// Operation codes
	localparam logic OP_CONSUME = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	typedef struct packed {
		logic                 operation;
		logic [CAT_FLD_W-1:0] category;
		logic [OPD_W-1:0]     duration_ticks;
		logic [OPD_W-1:0]     current_ua;
	} cau_req_t;

	typedef struct packed {
		logic [HOURS_W-1:0]   total_hours;
		logic [REM_OUT_W-1:0] total_remainder;
		logic [HOURS_W-1:0]   category_hours;
		logic [REM_OUT_W-1:0] category_remainder;
	} cau_rsp_t;

endpackage

FILE: src/cau_mul.sv
// ----------------------------------------------------------------------------
// cau_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle, product of two 32-bit operands.
// ----------------------------------------------------------------------------
module cau_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cau_pkg::OPD_W-1:0]   mcand,
	input  logic [cau_pkg::OPD_W-1:0]   mplier,
	output logic                        done,
	output logic [cau_pkg::PROD_W-1:0]  product
);
	import cau_pkg::*;

	logic [OPD_W-1:0]     hi_q;
	logic [OPD_W-1:0]     lo_q;
	logic [OPD_W-1:0]     mcand_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [OPD_W:0]       sum;

	// Partial sum of the upper half with the multiplicand
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// Datapath: add, then shift the whole product right one bit
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			lo_q    <= mplier;
			mcand_q <= mcand;
		end else if (busy_q) begin
			hi_q <= sum[OPD_W:1];
			lo_q <= {sum[0], lo_q[OPD_W-1:1]};
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == MUL_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

FILE: src/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div: bit-serial restoring divider by a constant
// One dividend bit per cycle, MSB first; keeps the low quotient word.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int              REM_W   = 27,
	parameter longint unsigned DIVISOR = 117964800
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cau_pkg::PROD_W-1:0]   dividend,
	output logic                         done,
	output logic [cau_pkg::HOURS_W-1:0]  quotient,
	output logic [REM_W-1:0]             remainder
);
	import cau_pkg::*;

	localparam logic [REM_W:0] DIV_EXT = (REM_W + 1)'(DIVISOR);

	logic [PROD_W-1:0]    dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [HOURS_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_W:0]       trial;
	logic [REM_W:0]       diff;
	logic                 ge;

	// Trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign ge    = trial >= DIV_EXT;
	assign diff  = trial - DIV_EXT;

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[HOURS_W-2:0], ge};
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: src/charge_accounting_unit.sv
// Sequence: a consume request runs the serial multiply, then the serial divide, then the finish
// state, which updates the accumulators and registers the result once the result slot is free.
// A clear request goes straight to the finish state, which zeroes the accumulators and the result.
// Requests: one at a time; no new request is taken until the last one has finished.
// Reset: arst_n clears control state and zeroes every accumulator at once.
// ----------------------------------------------------------------------------
// charge_accounting_unit: total and per-category charge accumulators
// Serial product of duration and current, split into hours and remainder.
// ----------------------------------------------------------------------------
module charge_accounting_unit #(
	parameter int CATEGORIES       = 4,
	parameter int TICKS_PER_SECOND = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cau_pkg::cau_req_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output cau_pkg::cau_rsp_t out_data
);
	import cau_pkg::*;

	localparam longint unsigned HOUR_TICKS =
		longint'(TICKS_PER_SECOND) * longint'(SECONDS_PER_HOUR);
	localparam int REM_W = $clog2(HOUR_TICKS + 1);
	localparam logic [REM_W:0] HOUR_EXT = (REM_W + 1)'(HOUR_TICKS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic                   clr_q;
	logic [CAT_FLD_W-1:0]   cat_q;
	logic                   out_valid_q;
	cau_rsp_t               out_data_q;

	logic [HOURS_W-1:0]     sum_hours_q;
	logic [REM_W-1:0]       sum_rem_q;
	logic [HOURS_W-1:0]     class_hours_q [CATEGORIES];
	logic [REM_W-1:0]       class_rem_q   [CATEGORIES];

	logic                   accept;
	logic                   mul_start;
	logic                   mul_done;
	logic [PROD_W-1:0]      product;
	logic                   div_done;
	logic [HOURS_W-1:0]     div_quo;
	logic [REM_W-1:0]       div_rem;
	logic                   fin_go;
	logic                   cat_ok;

	logic [HOURS_W-1:0]     sel_hours;
	logic [REM_W-1:0]       sel_rem;
	logic [REM_W:0]         tot_sum;
	logic                   tot_ge;
	logic [REM_W-1:0]       tot_rem_nx;
	logic [HOURS_W-1:0]     tot_hours_nx;
	logic [REM_W:0]         cat_sum;
	logic                   cat_ge;
	logic [REM_W-1:0]       cat_rem_nx;
	logic [HOURS_W-1:0]     cat_hours_nx;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign mul_start = accept && (in_data.operation == OP_CONSUME);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign cat_ok    = int'(cat_q) < CATEGORIES;

	// Serial multiply of duration by current
	cau_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (in_data.current_ua),
		.mplier  (in_data.duration_ticks),
		.done    (mul_done),
		.product (product)
	);

	// Serial split of the product into hours and remainder ticks
	cau_div #(
		.REM_W   (REM_W),
		.DIVISOR (HOUR_TICKS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mul_done),
		.dividend  (product),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Read the addressed category; out-of-range reads as zero
	always_comb begin
		sel_hours = '0;
		sel_rem   = '0;
		for (int i = 0; i < CATEGORIES; i++) begin
			if (int'(cat_q) == i) begin
				sel_hours = class_hours_q[i];
				sel_rem   = class_rem_q[i];
			end
		end
	end

	// Fold product remainder into the total and the addressed category, carry into hours
	always_comb begin
		tot_sum      = {1'b0, sum_rem_q} + {1'b0, div_rem};
		tot_ge       = tot_sum >= HOUR_EXT;
		tot_rem_nx   = tot_ge ? REM_W'(tot_sum - HOUR_EXT) : REM_W'(tot_sum);
		tot_hours_nx = sum_hours_q + div_quo + HOURS_W'(tot_ge);
		cat_sum      = {1'b0, sel_rem} + {1'b0, div_rem};
		cat_ge       = cat_sum >= HOUR_EXT;
		cat_rem_nx   = cat_ge ? REM_W'(cat_sum - HOUR_EXT) : REM_W'(cat_sum);
		cat_hours_nx = sel_hours + div_quo + HOURS_W'(cat_ge);
	end

	// Accumulator update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_hours_q <= '0;
			sum_rem_q   <= '0;
			for (int i = 0; i < CATEGORIES; i++) begin
				class_hours_q[i] <= '0;
				class_rem_q[i]   <= '0;
			end
		end else if (fin_go) begin
			if (clr_q) begin
				sum_hours_q <= '0;
				sum_rem_q   <= '0;
				for (int i = 0; i < CATEGORIES; i++) begin
					class_hours_q[i] <= '0;
					class_rem_q[i]   <= '0;
				end
			end else begin
				sum_hours_q <= tot_hours_nx;
				sum_rem_q   <= tot_rem_nx;
				for (int i = 0; i < CATEGORIES; i++) begin
					if (int'(cat_q) == i) begin
						class_hours_q[i] <= cat_hours_nx;
						class_rem_q[i]   <= cat_rem_nx;
					end
				end
			end
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= 1'b0;
			cat_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// Result slot: filled on finish, emptied when taken
			out_valid_q <= fin_go || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						clr_q   <= (in_data.operation == OP_CLEAR);
						cat_q   <= in_data.category;
						state_q <= (in_data.operation == OP_CLEAR) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						if (clr_q) begin
							out_data_q <= '0;
						end else begin
							out_data_q.total_hours     <= tot_hours_nx;
							out_data_q.total_remainder <= REM_OUT_W'(tot_rem_nx);
							if (cat_ok) begin
								out_data_q.category_hours     <= cat_hours_nx;
								out_data_q.category_remainder <= REM_OUT_W'(cat_rem_nx);
							end else begin
								out_data_q.category_hours     <= '0;
								out_data_q.category_remainder <= '0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// Remainder of the total always stays below one hour of ticks
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, sum_rem_q} < HOUR_EXT)
		else $error("total remainder out of range");

	// Multiplier finishes only while the sequencer waits for it
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MUL)
		else $error("multiplier done outside multiply phase");

	// Divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside divide phase");

	// One request in flight: no acceptance right after an acceptance
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted while busy");
`endif

endmodule
